@@ hdl/sspq_pkg.sv @@
// ----------------------------------------------------------------------------
// sspq_pkg
// Types and constants shared by the stable sorted priority queue modules.
// ----------------------------------------------------------------------------
package sspq_pkg;

  // default number of queue slots
  localparam int DEPTH_DEF = 16;

  // action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // input item
  typedef struct packed {
    logic               action;
    logic signed [15:0] priority_req;
    logic        [15:0] payload_tag;
  } sspq_in_t;

  // result item
  typedef struct packed {
    logic        [1:0]  status;
    logic               front_valid;
    logic signed [15:0] front_priority;
    logic        [15:0] front_tag;
    logic        [4:0]  count;
  } sspq_out_t;

  // one stored entry
  typedef struct packed {
    logic               valid;
    logic signed [15:0] prio;
    logic        [15:0] tag;
  } sspq_ent_t;

  // what a cell shows its neighbors
  typedef struct packed {
    sspq_ent_t ent;
    logic      keep;  // entry stays put on an enqueue (prio <= new prio)
  } sspq_cell_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic               enq;
    logic               deq;
    logic signed [15:0] prio;
    logic        [15:0] tag;
  } sspq_ctl_t;

endpackage

@@ hdl/sspq_cell.sv @@
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted queue: holds an entry, compares it with the new
// priority and shifts right on an insert or left on a removal.
// ----------------------------------------------------------------------------
module sspq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sspq_pkg::sspq_ctl_t ctl_i,
  input  sspq_pkg::sspq_cell_t left_i,
  input  sspq_pkg::sspq_ent_t right_i,
  output sspq_pkg::sspq_cell_t state_o,
  output sspq_pkg::sspq_ent_t nxt_o
);
  import sspq_pkg::*;

  sspq_ent_t ent_r;
  sspq_ent_t ent_nxt;
  logic      keep;

  // entry stays in place when it sorts before or equal to the new one
  assign keep = ent_r.valid && ($signed(ent_r.prio) <= $signed(ctl_i.prio));

  assign state_o.ent  = ent_r;
  assign state_o.keep = keep;
  assign nxt_o        = ent_nxt;

  // next entry: hold, take new item, shift from left or shift from right
  always_comb begin
    ent_nxt = ent_r;
    if (ctl_i.enq && !keep) begin
      if (left_i.keep) begin
        ent_nxt.valid = 1'b1;
        ent_nxt.prio  = ctl_i.prio;
        ent_nxt.tag   = ctl_i.tag;
      end else begin
        ent_nxt = left_i.ent;
      end
    end else if (ctl_i.deq) begin
      ent_nxt = right_i;
    end
  end

  // valid bit is control, entry data needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.prio <= ent_nxt.prio;
    ent_r.tag  <= ent_nxt.tag;
  end

endmodule

@@ hdl/stable_sorted_priority_queue.sv @@
// Latency: the result item is registered in the cycle after the input item is accepted.
// Throughput: one item per cycle while results are taken; every cell compares and shifts in that same cycle.
// A stalled result blocks input only while the output register is still full.
// Reset: all cells invalid and the count zero; entry data is left as is.
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Priority queue kept as a row of sorted cells; equal priorities leave in
// arrival order. Every item returns the status, the front entry and the count.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue #(
  parameter int DEPTH = sspq_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sspq_pkg::sspq_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sspq_pkg::sspq_out_t out_item
);
  import sspq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  sspq_cell_t      cell_st  [DEPTH];
  sspq_ent_t       cell_nxt [DEPTH];
  sspq_ctl_t       ctl;
  logic            fire;
  logic            full;
  logic            empty;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  sspq_out_t       out_r;
  sspq_out_t       out_nxt;

  // handshake: take an item whenever the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign full     = cell_st[DEPTH-1].ent.valid;
  assign empty    = !cell_st[0].ent.valid;

  // command broadcast to the cells
  always_comb begin
    ctl.enq  = fire && (in_item.action == ACT_ENQ) && !full;
    ctl.deq  = fire && (in_item.action == ACT_DEQ) && !empty;
    ctl.prio = in_item.priority_req;
    ctl.tag  = in_item.payload_tag;
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sspq_cell_t left;
    sspq_ent_t  right;
    if (i == 0) begin : g_first
      // head boundary: always "keeps", so a new item that sorts first lands in the first cell
      assign left = '{ent: '{valid: 1'b1, prio: '0, tag: '0}, keep: 1'b1};
    end else begin : g_mid
      assign left = cell_st[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '{valid: 1'b0, prio: '0, tag: '0};
    end else begin : g_inner
      assign right = cell_st[i+1].ent;
    end
    sspq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl),
      .left_i  (left),
      .right_i (right),
      .state_o (cell_st[i]),
      .nxt_o   (cell_nxt[i])
    );
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (ctl.enq) begin
      count_nxt = count_r + CntW'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  // result item from the front cell after the step
  always_comb begin
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (fire) begin
      out_valid_nxt       = 1'b1;
      out_nxt.status      = ST_DONE;
      if ((in_item.action == ACT_ENQ) && full) begin
        out_nxt.status = ST_FULL;
      end else if ((in_item.action == ACT_DEQ) && empty) begin
        out_nxt.status = ST_EMPTY;
      end
      out_nxt.front_valid = cell_nxt[0].valid;
      if (cell_nxt[0].valid) begin
        out_nxt.front_priority = cell_nxt[0].prio;
        out_nxt.front_tag      = cell_nxt[0].tag;
      end else begin
        out_nxt.front_priority = '0;
        out_nxt.front_tag      = '0;
      end
      out_nxt.count = 5'(count_nxt);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stable_sorted_priority_queue. Each accepted item
// runs through a behavioral copy of the sorted queue. Every report that comes
// out is compared field by field with the oldest pending expected report.
// The bench covers directed corner cases, fill and overflow, random traffic
// that hovers around moving occupancy targets under several idle and stall
// mixes, and a long output hold that backs the queue up.
// ----------------------------------------------------------------------------
module tb_top;
  import sspq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sspq_in_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sspq_out_t out_item;

  // shadow of the queue contents, kept in sorted order
  logic signed [15:0] held_prio [DEPTH];
  logic        [15:0] held_tag [DEPTH];
  int                 held_count = 0;

  sspq_out_t expected_reports [$];
  int        error_count = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        hold_left = 0;

  stable_sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  // apply one operation to the shadow queue and return the report it gives
  function automatic sspq_out_t next_queue_report(input sspq_in_t it);
    sspq_out_t          rep;
    logic signed [15:0] p;
    int                 pos;
    rep = '0;
    rep.status = ST_DONE;
    p = it.priority_req;
    if (it.action == ACT_ENQ) begin
      if (held_count >= DEPTH) begin
        rep.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of lower or equal priority
        pos = 0;
        while (pos < held_count && $signed(held_prio[pos]) <= $signed(p)) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_prio[i] = held_prio[i-1];
          held_tag[i] = held_tag[i-1];
        end
        held_prio[pos] = p;
        held_tag[pos] = it.payload_tag;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        rep.status = ST_EMPTY;
      end else begin
        for (int i = 0; i + 1 < held_count; i++) begin
          held_prio[i] = held_prio[i+1];
          held_tag[i] = held_tag[i+1];
        end
        held_count--;
      end
    end
    if (held_count > 0) begin
      rep.front_valid = 1'b1;
      rep.front_priority = held_prio[0];
      rep.front_tag = held_tag[0];
    end
    rep.count = 5'(held_count);
    return rep;
  endfunction

  function automatic sspq_in_t make_item(input logic act, input logic signed [15:0] p,
                                         input logic [15:0] t);
    sspq_in_t it;
    it.action = act;
    it.priority_req = p;
    it.payload_tag = t;
    return it;
  endfunction

  // mostly a narrow band so ties are common, sometimes wide or extreme
  function automatic logic signed [15:0] pick_priority();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 16'($signed($urandom_range(0, 6)) - 3);
    else if (sel < 8) return 16'($urandom_range(0, 16'hFFFF));
    else if (sel == 8) return 16'sh8000;
    else return 16'sh7FFF;
  endfunction

  // offer one item, hold it until taken, then predict its report
  task automatic send_item(input sspq_in_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_reports.push_back(next_queue_report(it));
  endtask

  // stop offering items until every pending report has come back
  task automatic wait_for_drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_reports.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    @(posedge clk);
  endtask

  // extremes, ties, ignored fields and dequeue on empty
  task automatic test_directed();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_item(make_item(ACT_DEQ, 16'sh0000, 16'h0000));
    send_item(make_item(ACT_ENQ, 16'sh7FFF, 16'hFFFF));
    send_item(make_item(ACT_ENQ, 16'sh8000, 16'h0000));
    send_item(make_item(ACT_ENQ, 16'sh0000, 16'h0001));
    send_item(make_item(ACT_ENQ, 16'sh0000, 16'h0002));
    send_item(make_item(ACT_ENQ, -16'sd1, 16'h0003));
    send_item(make_item(ACT_ENQ, 16'sh0000, 16'hA5A5));
    send_item(make_item(ACT_DEQ, 16'shFFFF, 16'hFFFF));
    send_item(make_item(ACT_DEQ, 16'sh5A5A, 16'h5A5A));
    send_item(make_item(ACT_DEQ, 16'sh0000, 16'h0000));
    send_item(make_item(ACT_DEQ, 16'sh8000, 16'h0000));
    send_item(make_item(ACT_DEQ, 16'sh7FFF, 16'hFFFF));
    send_item(make_item(ACT_DEQ, 16'sh0000, 16'h0000));
    send_item(make_item(ACT_DEQ, 16'sh1234, 16'h4321));
  endtask

  // fill with many ties, push twice into a full queue, then drain past empty
  task automatic test_fill_and_overflow();
    for (int k = 0; k < DEPTH; k++) begin
      send_item(make_item(ACT_ENQ, 16'($signed($urandom_range(0, 3)) - 2), 16'(k)));
    end
    send_item(make_item(ACT_ENQ, 16'sh8000, 16'hFFFF));
    send_item(make_item(ACT_ENQ, 16'sh7FFF, 16'h0000));
    for (int k = 0; k <= DEPTH; k++) begin
      send_item(make_item(ACT_DEQ, 16'($urandom_range(0, 16'hFFFF)),
                          16'($urandom_range(0, 16'hFFFF))));
    end
  endtask

  // random traffic drifting toward an occupancy target that moves now and then
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_items);
    sspq_in_t it;
    int       target;
    int       roll;
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    target = $urandom_range(0, DEPTH);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 29) == 0) target = $urandom_range(0, DEPTH);
      it.priority_req = pick_priority();
      it.payload_tag = 16'($urandom_range(0, 16'hFFFF));
      roll = $urandom_range(0, 9);
      if ($urandom_range(0, 9) == 0) begin
        it.action = 1'($urandom_range(0, 1));
      end else if (held_count < target) begin
        it.action = (roll < 8) ? ACT_ENQ : ACT_DEQ;
      end else if (held_count > target) begin
        it.action = (roll < 8) ? ACT_DEQ : ACT_ENQ;
      end else begin
        it.action = (roll < 5) ? ACT_ENQ : ACT_DEQ;
      end
      send_item(it);
    end
    wait_for_drain();
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_left = 80;
    for (int k = 0; k < 24; k++) begin
      send_item(make_item(($urandom_range(0, 3) == 0) ? ACT_DEQ : ACT_ENQ,
                          pick_priority(), 16'($urandom_range(0, 16'hFFFF))));
    end
    wait_for_drain();
  endtask

  // receiver: long hold when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // compare each delivered report with the oldest expectation
  always @(posedge clk) begin
    sspq_out_t exp_rep;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        if (error_count < 10) begin
          $display("%0t: report with nothing pending: status=%0d valid=%0d prio=%0d tag=%h count=%0d",
                   $realtime, out_item.status, out_item.front_valid,
                   out_item.front_priority, out_item.front_tag, out_item.count);
        end
        error_count++;
      end else begin
        exp_rep = expected_reports.pop_front();
        if (out_item.status !== exp_rep.status ||
            out_item.front_valid !== exp_rep.front_valid ||
            out_item.front_priority !== exp_rep.front_priority ||
            out_item.front_tag !== exp_rep.front_tag ||
            out_item.count !== exp_rep.count) begin
          if (error_count < 10) begin
            $display("%0t: mismatch expected status=%0d valid=%0d prio=%0d tag=%h count=%0d",
                     $realtime, exp_rep.status, exp_rep.front_valid,
                     exp_rep.front_priority, exp_rep.front_tag, exp_rep.count);
            $display("%0t:          got      status=%0d valid=%0d prio=%0d tag=%h count=%0d",
                     $realtime, out_item.status, out_item.front_valid,
                     out_item.front_priority, out_item.front_tag, out_item.count);
          end
          error_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("stable_sorted_priority_queue test failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_for_drain();
    test_fill_and_overflow();
    wait_for_drain();
    run_random_phase(0, 0, 210);
    run_random_phase(51, 0, 210);
    test_output_backpressure();
    run_random_phase(0, 51, 210);
    run_random_phase(10, 10, 210);
    wait_for_drain();
    repeat (8) @(posedge clk);
    error_count += expected_reports.size();
    if (error_count == 0) begin
      $display("stable_sorted_priority_queue test passed");
    end else begin
      $display("stable_sorted_priority_queue test failed");
    end
    $finish;
  end

endmodule
